// File: hdl/assert_macros.svh
// Assertion macros used by the frame decoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define PWFD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold at the next clock edge.
`define PWFD_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/pwfd_pkg.sv
// Package with the types, constants and threshold function of the frame decoder.
`timescale 1ns / 1ps

package pwfd_pkg;

   localparam int UNIT_W    = 13;
   localparam int MARK_W    = 15;
   localparam int CHAN_W    = 3;
   localparam int WORD_W    = 32;
   localparam int COUNT_W   = 6;
   localparam int STATUS_W  = 2;
   localparam int THR_W     = 17;

   localparam logic [UNIT_W-1:0]  UNIT_RESET = 13'd600;
   localparam logic [COUNT_W-1:0] MAX_COUNT  = 6'd34;
   localparam logic [COUNT_W-1:0] LAST_BIT_POS = 6'd32;
   localparam logic [COUNT_W-1:0] LEN_SHORT  = 6'd23;
   localparam logic [COUNT_W-1:0] LEN_MID    = 6'd25;
   localparam logic [COUNT_W-1:0] LEN_LONG   = 6'd33;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_COUNT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_START = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_BIT   = 2'd3;

   // ceil(2^17 / 3); exact floor(u/3) for every u below 2^16.
   localparam int RECIP_SHIFT = 17;
   localparam int PROD_W      = UNIT_W + RECIP_SHIFT;
   localparam logic [PROD_W-1:0] RECIP_THIRD = PROD_W'(43691);

   typedef struct packed {
      logic [THR_W-1:0] start_lo;
      logic [THR_W-1:0] start_hi;
      logic [THR_W-1:0] one_lo;
      logic [THR_W-1:0] one_hi;
      logic [THR_W-1:0] zero_lo;
      logic [THR_W-1:0] zero_hi;
   } thresholds_type;

   typedef struct packed {
      logic start_good;
      logic bit_one;
      logic bit_zero;
   } mark_class_type;

   // Window edges for one unit length u with tolerance t = u/3.
   function automatic thresholds_type thr_calc(input logic [UNIT_W-1:0] unit);
      logic [PROD_W-1:0] prod;
      logic [THR_W-1:0]  u;
      logic [THR_W-1:0]  t;
      thresholds_type    thr;
      prod = PROD_W'(unit) * RECIP_THIRD;
      u = THR_W'(unit);
      t = THR_W'(prod[PROD_W-1:RECIP_SHIFT]);
      thr.start_lo = (u << 2) - t;
      thr.start_hi = (u << 2) + t;
      thr.one_lo   = (u << 1) - t;
      thr.one_hi   = (u << 1) + t;
      thr.zero_lo  = u - t;
      thr.zero_hi  = u + t;
      return thr;
   endfunction

endpackage

// File: hdl/pwfd_mark_class.sv
// Mark classifier: compares one mark length against the start, one and zero windows.
`timescale 1ns / 1ps

module pwfd_mark_class (
   input  logic [pwfd_pkg::MARK_W-1:0] mark_ticks,
   input  pwfd_pkg::thresholds_type    thr,
   output pwfd_pkg::mark_class_type    mark_class
);

   logic [pwfd_pkg::THR_W-1:0] mark_ext;

   assign mark_ext = pwfd_pkg::THR_W'(mark_ticks);

   // The start window is closed; the bit windows are open at both ends.
   assign mark_class.start_good = (mark_ext >= thr.start_lo) && (mark_ext <= thr.start_hi);
   assign mark_class.bit_one    = (mark_ext > thr.one_lo) && (mark_ext < thr.one_hi);
   assign mark_class.bit_zero   = (mark_ext > thr.zero_lo) && (mark_ext < thr.zero_hi);

endmodule

// File: hdl/pulse_width_frame_decoder_top.sv
// Top level of the mark-length coded frame decoder.
`timescale 1ns / 1ps
// Usage:
// The req_ channel carries one received mark per transfer: its length in
// ticks, a flag that marks the frame's last symbol, and the channel number.
// The first mark of a frame is the start mark; marks 2 to 33 carry data bits.
// A transfer with req_last_mark set closes the frame and yields exactly one
// transfer on the rsp_ channel with the left-aligned data word, the status,
// the channel and the saturated symbol count. Other marks yield nothing.
// The csr_ port writes the unit length in ticks; the window edges derived
// from it are registered on the write itself, so a mark may follow at once.
// A closing mark passes through the input register and the result register on its
// way to rsp_valid. Throughput is one mark per cycle unless a closing mark waits;
// the decision path is one set of compares against the registered windows.
// When the receiver stalls, the result register holds; marks that do not
// end a frame keep flowing, and a closing mark waits in the input register
// until the result is taken. Synchronous reset restores a unit of 600 ticks,
// clears the frame state and empties both registers.

module pulse_width_frame_decoder_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [pwfd_pkg::UNIT_W-1:0]    csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [pwfd_pkg::MARK_W-1:0]    req_mark_ticks,
   input  logic                           req_last_mark,
   input  logic [pwfd_pkg::CHAN_W-1:0]    req_channel,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [pwfd_pkg::WORD_W-1:0]    rsp_frame_word,
   output logic [pwfd_pkg::STATUS_W-1:0]  rsp_frame_status,
   output logic [pwfd_pkg::CHAN_W-1:0]    rsp_frame_channel,
   output logic [pwfd_pkg::COUNT_W-1:0]   rsp_symbol_total
);

`include "assert_macros.svh"

   // Window edges, recomputed on every register write.
   pwfd_pkg::thresholds_type thr_ff;

   // Input register.
   logic                          s1_valid_ff, s1_valid_in;
   logic [pwfd_pkg::MARK_W-1:0]   s1_mark_ff;
   logic                          s1_last_ff;
   logic [pwfd_pkg::CHAN_W-1:0]   s1_chan_ff;

   // Frame state.
   logic [pwfd_pkg::COUNT_W-1:0]  mark_count_ff, mark_count_in;
   logic [pwfd_pkg::WORD_W-1:0]   bit_word_ff, bit_word_in;
   logic                          start_bad_ff, start_bad_in;
   logic                          bit_bad_ff, bit_bad_in;

   // Result register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [pwfd_pkg::WORD_W-1:0]   rsp_word_ff;
   logic [pwfd_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [pwfd_pkg::CHAN_W-1:0]   rsp_chan_ff;
   logic [pwfd_pkg::COUNT_W-1:0]  rsp_total_ff;

   pwfd_pkg::mark_class_type      mark_class;
   logic                          s1_advance;
   logic [pwfd_pkg::COUNT_W-1:0]  count_sat;
   logic [pwfd_pkg::COUNT_W-1:0]  bit_index;
   logic [pwfd_pkg::WORD_W-1:0]   word_upd;
   logic                          start_bad_upd, bit_bad_upd;
   logic [pwfd_pkg::STATUS_W-1:0] status_calc;

   pwfd_mark_class u_mark_class (
      .mark_ticks (s1_mark_ff),
      .thr        (thr_ff),
      .mark_class (mark_class)
   );

   // A closing mark may move only when the result register is free or drains.
   assign s1_advance  = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || s1_advance;
   assign s1_valid_in = req_ready ? req_valid : s1_valid_ff;

   // Bit position 1 lands in bit 31, position 32 in bit 0.
   assign bit_index = pwfd_pkg::LAST_BIT_POS - mark_count_ff;
   assign count_sat = (mark_count_ff < pwfd_pkg::MAX_COUNT) ?
                      mark_count_ff + 6'd1 : mark_count_ff;

   always_comb begin
      word_upd      = bit_word_ff;
      start_bad_upd = start_bad_ff;
      bit_bad_upd   = bit_bad_ff;
      if (mark_count_ff == '0) begin
         start_bad_upd = start_bad_ff || !mark_class.start_good;
      end else if (mark_count_ff <= pwfd_pkg::LAST_BIT_POS) begin
         if (mark_class.bit_one) begin
            word_upd = bit_word_ff | (pwfd_pkg::WORD_W'(1) << bit_index[4:0]);
         end else if (!mark_class.bit_zero) begin
            bit_bad_upd = 1'b1;
         end
      end
   end

   // Status priority: frame length, then start mark, then data marks.
   always_comb begin
      if (!(count_sat inside {pwfd_pkg::LEN_SHORT, pwfd_pkg::LEN_MID, pwfd_pkg::LEN_LONG})) begin
         status_calc = pwfd_pkg::STATUS_BAD_COUNT;
      end else if (start_bad_upd) begin
         status_calc = pwfd_pkg::STATUS_BAD_START;
      end else if (bit_bad_upd) begin
         status_calc = pwfd_pkg::STATUS_BAD_BIT;
      end else begin
         status_calc = pwfd_pkg::STATUS_OK;
      end
   end

   // Frame state moves with each mark and clears once a frame closes.
   always_comb begin
      mark_count_in = mark_count_ff;
      bit_word_in   = bit_word_ff;
      start_bad_in  = start_bad_ff;
      bit_bad_in    = bit_bad_ff;
      if (s1_advance) begin
         if (s1_last_ff) begin
            mark_count_in = '0;
            bit_word_in   = '0;
            start_bad_in  = 1'b0;
            bit_bad_in    = 1'b0;
         end else begin
            mark_count_in = count_sat;
            bit_word_in   = word_upd;
            start_bad_in  = start_bad_upd;
            bit_bad_in    = bit_bad_upd;
         end
      end
   end

   always_comb begin
      if (s1_advance && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff        <= pwfd_pkg::thr_calc(pwfd_pkg::UNIT_RESET);
         s1_valid_ff   <= 1'b0;
         mark_count_ff <= '0;
         bit_word_ff   <= '0;
         start_bad_ff  <= 1'b0;
         bit_bad_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            thr_ff <= pwfd_pkg::thr_calc(csr_wr_data);
         end
         s1_valid_ff   <= s1_valid_in;
         mark_count_ff <= mark_count_in;
         bit_word_ff   <= bit_word_in;
         start_bad_ff  <= start_bad_in;
         bit_bad_ff    <= bit_bad_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_mark_ff <= req_mark_ticks;
         s1_last_ff <= req_last_mark;
         s1_chan_ff <= req_channel;
      end
      if (s1_advance && s1_last_ff) begin
         rsp_word_ff   <= (status_calc == pwfd_pkg::STATUS_OK) ? word_upd : '0;
         rsp_status_ff <= status_calc;
         rsp_chan_ff   <= s1_chan_ff;
         rsp_total_ff  <= count_sat;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_word    = rsp_word_ff;
   assign rsp_frame_status  = rsp_status_ff;
   assign rsp_frame_channel = rsp_chan_ff;
   assign rsp_symbol_total  = rsp_total_ff;

   // A failed frame never shows data bits.
   `PWFD_ASSERT(a_err_word_zero,
      !rsp_valid_ff || rsp_status_ff == pwfd_pkg::STATUS_OK || rsp_word_ff == '0,
      "failed frame carries a nonzero word")

   // A good frame always has one of the legal lengths.
   `PWFD_ASSERT(a_ok_length,
      !rsp_valid_ff || rsp_status_ff != pwfd_pkg::STATUS_OK ||
      rsp_total_ff == pwfd_pkg::LEN_SHORT || rsp_total_ff == pwfd_pkg::LEN_MID ||
      rsp_total_ff == pwfd_pkg::LEN_LONG,
      "good frame with an illegal length")

   // A closing mark leaves the frame state cleared and a result pending.
   `PWFD_ASSERT_NEXT(a_close_clears, s1_advance && s1_last_ff,
      mark_count_ff == '0 && bit_word_ff == '0 && rsp_valid_ff,
      "frame close did not clear state or post a result")

   // The mark counter never passes its saturation point.
   `PWFD_ASSERT(a_count_sat, mark_count_ff <= pwfd_pkg::MAX_COUNT,
      "mark counter beyond saturation")

endmodule

// File: tb/sv/pwfd_frame_scoreboard.sv
// Scoreboard class that predicts and checks decoded frames of the frame decoder.
`timescale 1ns / 1ps

package pwfd_tb_pkg;

   typedef struct packed {
      logic [pwfd_pkg::WORD_W-1:0]   word;
      logic [pwfd_pkg::STATUS_W-1:0] status;
      logic [pwfd_pkg::CHAN_W-1:0]   channel;
      logic [pwfd_pkg::COUNT_W-1:0]  total;
   } frame_result_type;

   class frame_scoreboard;
      logic [pwfd_pkg::UNIT_W-1:0]  unit_ticks;
      logic [pwfd_pkg::COUNT_W-1:0] mark_count;
      logic [pwfd_pkg::WORD_W-1:0]  bit_word;
      bit                           start_bad;
      bit                           bit_bad;
      frame_result_type             expected_frames[$];
      int                           errors;

      function new();
         unit_ticks = pwfd_pkg::UNIT_RESET;
         errors = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         mark_count = '0;
         bit_word = '0;
         start_bad = 1'b0;
         bit_bad = 1'b0;
      endfunction

      function void set_unit(input logic [pwfd_pkg::UNIT_W-1:0] value);
         unit_ticks = value;
      endfunction

      function int pending();
         return expected_frames.size();
      endfunction

      function int failures();
         return errors + expected_frames.size();
      endfunction

      // Classifies one accepted mark and queues a frame result when it closes the frame.
      function void note_mark(input logic [pwfd_pkg::MARK_W-1:0] mark, input logic last,
                              input logic [pwfd_pkg::CHAN_W-1:0] channel);
         int               m;
         int               u;
         int               t;
         int               pos;
         frame_result_type res;
         m = mark;
         u = unit_ticks;
         t = u / 3;
         pos = mark_count;
         if (pos == 0) begin
            if (m > 4 * u + t || m < 4 * u - t) start_bad = 1'b1;
         end else if (pos <= pwfd_pkg::LAST_BIT_POS) begin
            if (m < 2 * u + t && m > 2 * u - t) bit_word[pwfd_pkg::WORD_W - pos] = 1'b1;
            else if (!(m < u + t && m > u - t)) bit_bad = 1'b1;
         end
         if (mark_count < pwfd_pkg::MAX_COUNT) mark_count++;
         if (!last) return;
         if (mark_count != pwfd_pkg::LEN_SHORT && mark_count != pwfd_pkg::LEN_MID &&
             mark_count != pwfd_pkg::LEN_LONG)
            res.status = pwfd_pkg::STATUS_BAD_COUNT;
         else if (start_bad)
            res.status = pwfd_pkg::STATUS_BAD_START;
         else if (bit_bad)
            res.status = pwfd_pkg::STATUS_BAD_BIT;
         else
            res.status = pwfd_pkg::STATUS_OK;
         res.word = (res.status == pwfd_pkg::STATUS_OK) ? bit_word : '0;
         res.channel = channel;
         res.total = mark_count;
         expected_frames.push_back(res);
         clear_frame();
      endfunction

      // Compares one result transfer with the oldest queued frame.
      function void check_frame(input frame_result_type got);
         frame_result_type want;
         if (expected_frames.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: unexpected frame word=%h status=%0d channel=%0d total=%0d",
                        $realtime, got.word, got.status, got.channel, got.total);
            return;
         end
         want = expected_frames.pop_front();
         if (got.word !== want.word || got.status !== want.status ||
             got.channel !== want.channel || got.total !== want.total) begin
            errors++;
            if (errors <= 10)
               $display("%0t: frame mismatch exp word=%h status=%0d channel=%0d total=%0d %s",
                        $realtime, want.word, want.status, want.channel, want.total,
                        $sformatf("got word=%h status=%0d channel=%0d total=%0d",
                                  got.word, got.status, got.channel, got.total));
         end
      endfunction
   endclass

endpackage

// File: tb/sv/tb_top.sv
// Top-level testbench of the mark-length coded frame decoder.
`timescale 1ns / 1ps

module tb_top;

   // Kinds of mark the stimulus can ask for; each maps to a window of the current unit.
   typedef enum int {
      MK_START_GOOD,
      MK_START_BAD,
      MK_BIT_ONE,
      MK_BIT_ZERO,
      MK_BIT_BAD,
      MK_NOISE
   } mark_kind_type;

   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_ITEMS  = 220;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 10;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_wr_en = 1'b0;
   logic [pwfd_pkg::UNIT_W-1:0]    csr_wr_data = '0;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [pwfd_pkg::MARK_W-1:0]    req_mark_ticks = '0;
   logic                           req_last_mark = 1'b0;
   logic [pwfd_pkg::CHAN_W-1:0]    req_channel = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [pwfd_pkg::WORD_W-1:0]    rsp_frame_word;
   logic [pwfd_pkg::STATUS_W-1:0]  rsp_frame_status;
   logic [pwfd_pkg::CHAN_W-1:0]    rsp_frame_channel;
   logic [pwfd_pkg::COUNT_W-1:0]   rsp_symbol_total;

   pwfd_tb_pkg::frame_scoreboard frame_sb;

   // Unit currently programmed into the block; the mark generator derives its windows from it.
   int cur_unit = pwfd_pkg::UNIT_RESET;
   // Percentages of cycles in which the sender or the receiver idles.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   // Remaining cycles of a forced receiver stall.
   int rsp_hold_left = 0;
   int items_sent = 0;
   int phase_items = 0;

   pulse_width_frame_decoder_top u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mark_ticks    (req_mark_ticks),
      .req_last_mark     (req_last_mark),
      .req_channel       (req_channel),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_word    (rsp_frame_word),
      .rsp_frame_status  (rsp_frame_status),
      .rsp_frame_channel (rsp_frame_channel),
      .rsp_symbol_total  (rsp_symbol_total)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The receiver decides its ready at each falling edge. A forced stall is counted down
   // here while the sender keeps offering marks, so that the block fills up and has to
   // stall its input.
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_ready = 1'b0;
         rsp_hold_left--;
      end else begin
         rsp_ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Every result transfer seen at a rising edge is checked against the oldest
   // expected frame.
   always @(posedge clock) begin
      pwfd_tb_pkg::frame_result_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         got.word = rsp_frame_word;
         got.status = rsp_frame_status;
         got.channel = rsp_frame_channel;
         got.total = rsp_symbol_total;
         frame_sb.check_frame(got);
      end
   end

   // A run that hangs is ended here. The bound is many times the slowest correct run.
   initial begin
      #(8 * 400000);
      $display("simulation failed");
      $finish;
   end

   function automatic logic [pwfd_pkg::MARK_W-1:0] clamp_mark(input int value);
      if (value < 0) return '0;
      if (value > 32767) return 15'h7FFF;
      return value[pwfd_pkg::MARK_W-1:0];
   endfunction

   // Picks the lower edge, the upper edge or a random point of an inclusive window.
   // An empty window, which a tiny unit produces, degrades to its lower edge.
   function automatic logic [pwfd_pkg::MARK_W-1:0] pick_between(input int lo, input int hi);
      int roll;
      if (hi > 32767) hi = 32767;
      if (hi < lo) return clamp_mark(lo);
      roll = $urandom_range(3);
      if (roll == 0) return clamp_mark(lo);
      if (roll == 1) return clamp_mark(hi);
      return clamp_mark($urandom_range(hi, lo));
   endfunction

   function automatic logic [pwfd_pkg::MARK_W-1:0] gen_mark(input mark_kind_type kind);
      int u;
      int t;
      int roll;
      u = cur_unit;
      t = u / 3;
      roll = $urandom_range(3);
      case (kind)
         MK_START_GOOD: begin
            return pick_between(4 * u - t, 4 * u + t);
         end
         MK_START_BAD: begin
            // Just outside either edge of the start window, anywhere up to its lower edge, or anywhere at all.
            if (roll == 0) return clamp_mark(4 * u - t - 1);
            if (roll == 1) return clamp_mark(4 * u + t + 1);
            if (roll == 2) return clamp_mark($urandom_range(4 * u - t));
            return clamp_mark($urandom_range(32767));
         end
         // The bit windows are open, so the good marks stay one tick inside each edge.
         MK_BIT_ONE: begin
            return pick_between(2 * u - t + 1, 2 * u + t - 1);
         end
         MK_BIT_ZERO: begin
            return pick_between(u - t + 1, u + t - 1);
         end
         MK_BIT_BAD: begin
            // The exact window edges are errors; so is most of the remaining range.
            if (roll == 0) return clamp_mark($urandom_range(1) ? u - t : u + t);
            if (roll == 1) return clamp_mark($urandom_range(1) ? 2 * u - t : 2 * u + t);
            if (roll == 2) return clamp_mark($urandom_range(u - t));
            return clamp_mark($urandom_range(32767));
         end
         default: begin
            return clamp_mark($urandom_range(32767));
         end
      endcase
   endfunction

   // Offers one mark and returns at the falling edge after its transfer. The task is
   // entered at a falling edge; valid drops there after the transfer, and a mark that
   // follows at once raises it again in the same time step, so no cycle is lost.
   task automatic send_mark(input logic [pwfd_pkg::MARK_W-1:0] mark, input logic last,
                            input logic [pwfd_pkg::CHAN_W-1:0] channel);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_mark_ticks = mark;
      req_last_mark = last;
      req_channel = channel;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      frame_sb.note_mark(mark, last, channel);
      items_sent++;
      phase_items++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Sends one frame. Most frames have a legal length and most have clean marks; some carry
   // a bad start mark or scattered bad bits and a few are pure noise. The other frames get a
   // random length of 1 to 40 marks, including frames longer than 33 where the count saturates.
   task automatic send_random_frame();
      int            len;
      int            roll;
      int            bit_err_pct;
      bit            start_bad;
      bit            noise;
      mark_kind_type kind;
      roll = $urandom_range(99);
      if (roll < 75) begin
         case ($urandom_range(2))
            0: len = pwfd_pkg::LEN_SHORT;
            1: len = pwfd_pkg::LEN_MID;
            default: len = pwfd_pkg::LEN_LONG;
         endcase
      end else begin
         len = $urandom_range(40, 1);
      end
      roll = $urandom_range(99);
      start_bad = 1'b0;
      noise = 1'b0;
      bit_err_pct = 0;
      if (roll < 5) begin
         noise = 1'b1;
      end else if (roll < 35) begin
         start_bad = ($urandom_range(3) == 0);
         bit_err_pct = 4;
      end
      for (int i = 0; i < len; i++) begin
         if (noise)
            kind = MK_NOISE;
         else if (i == 0)
            kind = start_bad ? MK_START_BAD : MK_START_GOOD;
         else if ($urandom_range(99) < bit_err_pct)
            kind = MK_BIT_BAD;
         else
            kind = $urandom_range(1) ? MK_BIT_ONE : MK_BIT_ZERO;
         send_mark(gen_mark(kind), i == len - 1, pwfd_pkg::CHAN_W'($urandom_range(6)));
      end
   endtask

   // The unit is only rewritten with the block idle: every expected frame has come back,
   // and an extra wait lets any trailing mark clear the two pipeline registers.
   task automatic write_unit(input int value);
      while (frame_sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_data = pwfd_pkg::UNIT_W'(value);
      csr_wr_en = 1'b1;
      @(negedge clock);
      csr_wr_en = 1'b0;
      frame_sb.set_unit(pwfd_pkg::UNIT_W'(value));
      cur_unit = value;
   endtask

   // The first third of the run has a slow receiver, the second a slow sender, and the
   // last third runs with no idling at all.
   task automatic set_idling();
      if (items_sent < 600) begin
         send_idle_pct = 30;
         recv_idle_pct = 67;
      end else if (items_sent < 1200) begin
         send_idle_pct = 67;
         recv_idle_pct = 30;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   initial begin
      int next_unit;
      int u;
      int t;
      frame_sb = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      set_idling();

      // Directed opening at the reset unit. Two single-mark frames carry the extreme mark
      // lengths on channels 0 and 6 and report a bad symbol count; then a clean 23-mark frame
      // uses the lowest legal start mark and bit marks one tick inside each window edge.
      send_mark(15'h0000, 1'b1, 3'd0);
      send_mark(15'h7FFF, 1'b1, 3'd6);
      u = cur_unit;
      t = u / 3;
      send_mark(clamp_mark(4 * u - t), 1'b0, 3'd1);
      for (int i = 1; i < pwfd_pkg::LEN_SHORT; i++) begin
         case (i % 4)
            0: next_unit = 2 * u - t + 1;
            1: next_unit = 2 * u + t - 1;
            2: next_unit = u - t + 1;
            default: next_unit = u + t - 1;
         endcase
         send_mark(clamp_mark(next_unit), i == pwfd_pkg::LEN_SHORT - 1, 3'd5);
      end

      // Random phases, each at its own unit: the smallest useful unit, the largest value
      // the register holds, a zero and a tiny unit, the top of the normal range, the reset
      // value and random units in between.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: next_unit = 3;
            1: next_unit = 8191;
            2: next_unit = 0;
            3: next_unit = 1;
            4: next_unit = $urandom_range(6553, 3);
            5: next_unit = 6553;
            6: next_unit = pwfd_pkg::UNIT_RESET;
            default: next_unit = $urandom_range(40, 3);
         endcase
         write_unit(next_unit);
         // One long receiver stall early in the run so that closing marks back up.
         if (p == 1) rsp_hold_left = HOLD_CYCLES;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            set_idling();
            send_random_frame();
         end
      end

      // Drain: wait for every expected frame, then watch a little longer for anything spurious.
      while (frame_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (frame_sb.failures() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hdl
hdl/pwfd_pkg.sv
hdl/pwfd_mark_class.sv
hdl/pulse_width_frame_decoder_top.sv
tb/sv/pwfd_frame_scoreboard.sv
tb/sv/tb_top.sv
